// ===== hdl/fm4op_pkg.sv =====
// ----------------------------------------------------------------------------
// fm4op_pkg
// Shared constants for the four-operator FM voice: register indexes,
// routing codes, sine polynomial coefficients and datapath widths.
// ----------------------------------------------------------------------------
package fm4op_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 23;
    localparam int ENV_W      = 16;
    localparam int RATIO_W    = 16;
    localparam int LEVEL_W    = 16;
    localparam int SAMPLE_W   = 18;
    localparam int ALG_W      = 2;
    localparam int ERATIO_W   = 24;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_ADDR_W-1:0] REG_ALGORITHM = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_OP2 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_OP3 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_OP4 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_OP1 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_OP2 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_OP3 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_OP4 = 3'd7;

    localparam logic [ALG_W-1:0] ALG_CHAIN = 2'd0;
    localparam logic [ALG_W-1:0] ALG_PAIR  = 2'd1;
    localparam logic [ALG_W-1:0] ALG_STACK = 2'd2;
    localparam logic [ALG_W-1:0] ALG_SUM   = 2'd3;

    localparam logic [15:0] SIN_A      = 16'd51472;
    localparam logic [15:0] SIN_B      = 16'd21024;
    localparam logic [15:0] SIN_C      = 16'd2320;
    localparam logic [15:0] SINE_MAX   = 16'd32767;
    localparam logic [15:0] HALF_TURN_Q = 16'd32768;
    localparam logic [MUL_B_W-1:0] MOD_SCALE = 24'd20860;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 16'd4096;

endpackage

// ===== hdl/fm_four_operator_voice.sv =====
// ----------------------------------------------------------------------------
// fm_four_operator_voice
// Four-operator FM voice: advances four phase accumulators per sample word,
// evaluates each operator on one shared 32x24 multiplier and routes them
// by the selected algorithm into one saturated sample.
// ----------------------------------------------------------------------------
// Sequence: five ratio/phase steps, then nine sequencer steps per operator
//   for four operators; the final OUT step waits until the output register is free.
// Flow: the single shared multiplier serialises words; a new one is taken only in idle.
// Reset: config registers return to their defaults, phases clear to zero.
// ----------------------------------------------------------------------------
module fm_four_operator_voice #(
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [fm4op_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [fm4op_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [fm4op_pkg::STEP_W-1:0]            s_phase_step,
    input  logic [fm4op_pkg::ENV_W-1:0]             s_env_op1,
    input  logic [fm4op_pkg::ENV_W-1:0]             s_env_op2,
    input  logic [fm4op_pkg::ENV_W-1:0]             s_env_op3,
    input  logic [fm4op_pkg::ENV_W-1:0]             s_env_op4,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [fm4op_pkg::SAMPLE_W-1:0]   m_sample_out
);
    import fm4op_pkg::*;

    localparam int TURN_W  = 32;
    localparam int X_SHIFT = 17 - SINE_ADDR_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_E3   = 4'd1;
    localparam logic [3:0] ST_E4   = 4'd2;
    localparam logic [3:0] ST_INC2 = 4'd3;
    localparam logic [3:0] ST_INC3 = 4'd4;
    localparam logic [3:0] ST_INC4 = 4'd5;
    localparam logic [3:0] ST_OFF  = 4'd6;
    localparam logic [3:0] ST_TURN = 4'd7;
    localparam logic [3:0] ST_X2   = 4'd8;
    localparam logic [3:0] ST_C    = 4'd9;
    localparam logic [3:0] ST_B    = 4'd10;
    localparam logic [3:0] ST_A    = 4'd11;
    localparam logic [3:0] ST_ENV  = 4'd12;
    localparam logic [3:0] ST_LVL  = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    logic [3:0]                 state_reg, state_next;
    logic [ALG_W-1:0]           alg_reg;
    logic [RATIO_W-1:0]         ratio2_reg, ratio3_reg, ratio4_reg;
    logic [LEVEL_W-1:0]         level_reg [4];
    logic [PHASE_BITS-1:0]      phase_reg [4];
    logic [STEP_W-1:0]          step_reg;
    logic [ENV_W-1:0]           env_reg [4];
    logic [ERATIO_W-1:0]        e3_reg, e4_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [1:0]                 op_reg;
    logic [15:0]                x_reg, x2_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] acc_reg, last_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod;
    logic [PHASE_BITS-1:0]      inc;
    logic [ERATIO_W-1:0]        eprod;
    logic [ERATIO_W-1:0]        e3_val;
    logic signed [SAMPLE_W-1:0] mod_sel;
    logic [TURN_W-1:0]          turn;
    logic [SINE_ADDR_BITS-1:0]  addr;
    logic [15:0]                x_raw, x_fold;
    logic [15:0]                prod_q15;
    logic [15:0]                sine_mag;
    logic [14:0]                mag;
    logic signed [SAMPLE_W-1:0] o_val;
    logic signed [SAMPLE_W:0]   sum_w;
    logic signed [SAMPLE_W-1:0] sum_sat;
    logic                       out_free;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_reg;
    assign out_free     = !m_valid_reg || m_ready;

    assign inc      = prod_reg[PHASE_BITS+11:12];
    assign eprod    = prod_reg[35:12];
    assign prod_q15 = prod_reg[30:15];
    assign e3_val   = (alg_reg == ALG_STACK) ? ERATIO_W'(ratio3_reg) : eprod;
    assign sine_mag = (prod_q15 > SINE_MAX) ? SINE_MAX : prod_q15;
    assign mag      = prod_reg[46:32];
    assign o_val    = neg_reg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});

    // modulation source for the current operator
    always_comb begin
        mod_sel = '0;
        unique case (op_reg)
            2'd3: mod_sel = '0;
            2'd2: mod_sel = (alg_reg == ALG_CHAIN) ? last_reg : '0;
            2'd1: begin
                if (alg_reg == ALG_CHAIN) begin
                    mod_sel = last_reg;
                end else if (alg_reg == ALG_PAIR) begin
                    mod_sel = acc_reg;
                end
            end
            2'd0: begin
                if (alg_reg == ALG_CHAIN || alg_reg == ALG_PAIR) begin
                    mod_sel = last_reg;
                end else if (alg_reg == ALG_STACK) begin
                    mod_sel = acc_reg;
                end
            end
        endcase
    end

    // fold the modulated phase into a quarter-wave argument
    always_comb begin
        turn   = (TURN_W'(phase_reg[op_reg]) << (TURN_W - PHASE_BITS)) + prod_reg[TURN_W-1:0];
        addr   = turn[TURN_W-1 -: SINE_ADDR_BITS];
        x_raw  = 16'(addr[SINE_ADDR_BITS-3:0]) << X_SHIFT;
        x_fold = addr[SINE_ADDR_BITS-2] ? (HALF_TURN_Q - x_raw) : x_raw;
    end

    always_comb begin
        sum_w = (alg_reg == ALG_SUM) ? ($signed({acc_reg[SAMPLE_W-1], acc_reg})
                                        + $signed({o_val[SAMPLE_W-1], o_val}))
                                     : $signed({o_val[SAMPLE_W-1], o_val});
        if (sum_w > $signed(19'sd131071)) begin
            sum_sat = 18'sh1FFFF;
        end else if (sum_w < $signed(-19'sd131072)) begin
            sum_sat = 18'sh20000;
        end else begin
            sum_sat = sum_w[SAMPLE_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_E3: begin
                mul_a = MUL_A_W'(ratio2_reg);
                mul_b = MUL_B_W'(ratio3_reg);
            end
            ST_E4: begin
                mul_a = (alg_reg == ALG_PAIR) ? MUL_A_W'(ratio2_reg) : MUL_A_W'(e3_val);
                mul_b = MUL_B_W'(ratio4_reg);
            end
            ST_INC2: begin
                mul_a = MUL_A_W'(ratio2_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            ST_INC3: begin
                mul_a = MUL_A_W'(e3_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            ST_INC4: begin
                mul_a = MUL_A_W'(e4_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            ST_OFF: begin
                mul_a = {{(MUL_A_W-SAMPLE_W){mod_sel[SAMPLE_W-1]}}, mod_sel};
                mul_b = MOD_SCALE;
            end
            ST_X2: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(x_reg);
            end
            ST_C: begin
                mul_a = MUL_A_W'(prod_q15);
                mul_b = MUL_B_W'(SIN_C);
            end
            ST_B: begin
                mul_a = MUL_A_W'(SIN_B - prod_q15);
                mul_b = MUL_B_W'(x2_reg);
            end
            ST_A: begin
                mul_a = MUL_A_W'(SIN_A - prod_q15);
                mul_b = MUL_B_W'(x_reg);
            end
            ST_ENV: begin
                mul_a = MUL_A_W'(sine_mag);
                mul_b = MUL_B_W'(env_reg[op_reg]);
            end
            ST_LVL: begin
                mul_a = MUL_A_W'(prod_reg[30:0]);
                mul_b = MUL_B_W'(level_reg[op_reg]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_E3;
            ST_E3:   state_next = ST_E4;
            ST_E4:   state_next = ST_INC2;
            ST_INC2: state_next = ST_INC3;
            ST_INC3: state_next = ST_INC4;
            ST_INC4: state_next = ST_OFF;
            ST_OFF:  state_next = ST_TURN;
            ST_TURN: state_next = ST_X2;
            ST_X2:   state_next = ST_C;
            ST_C:    state_next = ST_B;
            ST_B:    state_next = ST_A;
            ST_A:    state_next = ST_ENV;
            ST_ENV:  state_next = ST_LVL;
            ST_LVL:  state_next = ST_OUT;
            ST_OUT: begin
                if (op_reg != 2'd0) begin
                    state_next = ST_OFF;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            op_reg       <= 2'd0;
            alg_reg      <= ALG_CHAIN;
            ratio2_reg   <= RATIO_ONE;
            ratio3_reg   <= RATIO_ONE;
            ratio4_reg   <= RATIO_ONE;
            level_reg[0] <= 16'hFFFF;
            level_reg[1] <= '0;
            level_reg[2] <= '0;
            level_reg[3] <= '0;
            phase_reg[0] <= '0;
            phase_reg[1] <= '0;
            phase_reg[2] <= '0;
            phase_reg[3] <= '0;
        end else begin
            state_reg <= state_next;

            // hold the final product while the output word waits
            if (state_reg != ST_OUT) begin
                prod_reg <= prod;
            end

            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ALGORITHM: alg_reg      <= cfg_wdata[ALG_W-1:0];
                    REG_RATIO_OP2: ratio2_reg   <= cfg_wdata;
                    REG_RATIO_OP3: ratio3_reg   <= cfg_wdata;
                    REG_RATIO_OP4: ratio4_reg   <= cfg_wdata;
                    REG_LEVEL_OP1: level_reg[0] <= cfg_wdata;
                    REG_LEVEL_OP2: level_reg[1] <= cfg_wdata;
                    REG_LEVEL_OP3: level_reg[2] <= cfg_wdata;
                    REG_LEVEL_OP4: level_reg[3] <= cfg_wdata;
                endcase
            end

            if (state_reg == ST_OUT && op_reg == 2'd0 && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        step_reg   <= s_phase_step;
                        env_reg[0] <= s_env_op1;
                        env_reg[1] <= s_env_op2;
                        env_reg[2] <= s_env_op3;
                        env_reg[3] <= s_env_op4;
                    end
                end
                ST_E3: begin
                    acc_reg  <= '0;
                    last_reg <= '0;
                end
                ST_E4: begin
                    e3_reg <= e3_val;
                end
                ST_INC2: begin
                    e4_reg       <= (alg_reg == ALG_STACK) ? ERATIO_W'(ratio4_reg) : eprod;
                    phase_reg[0] <= phase_reg[0] + PHASE_BITS'(step_reg);
                end
                ST_INC3: begin
                    phase_reg[1] <= phase_reg[1] + inc;
                end
                ST_INC4: begin
                    phase_reg[2] <= phase_reg[2] + inc;
                    op_reg       <= 2'd3;
                end
                ST_OFF: begin
                    // first operator: product still holds the operator 4 increment
                    if (op_reg == 2'd3) begin
                        phase_reg[3] <= phase_reg[3] + inc;
                    end
                end
                ST_TURN: begin
                    x_reg   <= x_fold;
                    neg_reg <= addr[SINE_ADDR_BITS-1];
                end
                ST_C: begin
                    x2_reg <= prod_q15;
                end
                ST_OUT: begin
                    if (op_reg != 2'd0) begin
                        last_reg <= o_val;
                        acc_reg  <= acc_reg + o_val;
                        op_reg   <= op_reg - 2'd1;
                    end else if (out_free) begin
                        sample_reg <= sum_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
